### hdl/sbpp_pkg.sv
package sbpp_pkg;

  localparam int unsigned MAX_PARAMS = 128;

  localparam logic [7:0] SYNC_BYTE       = 8'hFF;
  localparam logic [7:0] BROADCAST_ID    = 8'hFE;
  localparam logic [7:0] SYNC_WRITE_INST = 8'h83;
  localparam logic [7:0] LEN_OVERHEAD    = 8'd2;
  localparam logic [7:0] MAX_PARAMS_B    = 8'(MAX_PARAMS);
  localparam logic [7:0] OWN_ID_RESET    = 8'd1;

  // Result kinds
  localparam logic [1:0] KIND_PARAM = 2'd0;
  localparam logic [1:0] KIND_GOOD  = 2'd1;
  localparam logic [1:0] KIND_BAD   = 2'd2;

  // Parser phases
  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_ID    = 3'd1;
  localparam logic [2:0] PH_LEN   = 3'd2;
  localparam logic [2:0] PH_INST  = 3'd3;
  localparam logic [2:0] PH_PARAM = 3'd4;
  localparam logic [2:0] PH_CSUM  = 3'd5;

  typedef struct packed {
    logic       fire;
    logic [7:0] data;
  } step_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] packet_id;
    logic [7:0] instruction;
    logic [7:0] param_index;
    logic [7:0] param_byte;
    logic [7:0] param_total;
    logic       broadcast;
  } res_t;

endpackage

### hdl/sbpp_byte_if.sv
interface sbpp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

### hdl/sbpp_result_if.sv
interface sbpp_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] packet_id;
  logic [7:0] instruction;
  logic [7:0] param_index;
  logic [7:0] param_byte;
  logic [7:0] param_total;
  logic       broadcast;

  modport source (output valid, output kind, output packet_id, output instruction,
                  output param_index, output param_byte, output param_total,
                  output broadcast, input ready);
  modport sink   (input valid, input kind, input packet_id, input instruction,
                  input param_index, input param_byte, input param_total,
                  input broadcast, output ready);
endinterface

### hdl/sbpp_input_stage.sv
module sbpp_input_stage (
  input  logic               clk,
  input  logic               rst,
  sbpp_byte_if.sink          rx,
  input  logic               out_free,
  output sbpp_pkg::step_t    step
);

  logic       held_valid;
  logic [7:0] held_byte;
  logic       advance;

  assign advance   = held_valid && out_free;
  assign rx.ready  = !held_valid || advance;
  assign step.fire = advance;
  assign step.data = held_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (rx.valid && rx.ready) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  // load a new word whenever the slot is free or draining
  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      held_byte <= rx.rx_byte;
    end
  end

endmodule

### hdl/sbpp_parse_core.sv
module sbpp_parse_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [7:0]         cfg_data,
  input  sbpp_pkg::step_t    step,
  output logic               res_valid,
  output sbpp_pkg::res_t     res
);

  logic [7:0] own_id;
  logic [7:0] older_byte, older_byte_next;
  logic [7:0] prev_byte, prev_byte_next;
  logic [2:0] phase, phase_next;
  logic [7:0] held_id, held_id_next;
  logic [7:0] held_instruction, held_instruction_next;
  logic [7:0] declared_params, declared_params_next;
  logic [7:0] params_seen, params_seen_next;
  logic [7:0] param_sum, param_sum_next;

  logic       sync;
  logic [2:0] ph;
  logic [7:0] b;
  logic [7:0] seen_inc;
  logic [7:0] total;

  assign b        = step.data;
  assign sync     = (older_byte == sbpp_pkg::SYNC_BYTE) && (prev_byte == sbpp_pkg::SYNC_BYTE);
  assign ph       = sync ? sbpp_pkg::PH_ID : phase;
  assign seen_inc = params_seen + 8'd1;
  assign total    = held_id + sbpp_pkg::LEN_OVERHEAD + held_instruction
                    + declared_params + param_sum;

  always_comb begin
    older_byte_next       = prev_byte;
    prev_byte_next        = b;
    phase_next            = ph;
    held_id_next          = held_id;
    held_instruction_next = held_instruction;
    declared_params_next  = declared_params;
    params_seen_next      = params_seen;
    param_sum_next        = param_sum;
    res_valid             = 1'b0;
    res.kind              = sbpp_pkg::KIND_PARAM;
    res.packet_id         = held_id;
    res.instruction       = held_instruction;
    res.param_index       = params_seen;
    res.param_byte        = 8'd0;
    res.param_total       = declared_params;
    res.broadcast         = (held_id == sbpp_pkg::BROADCAST_ID);
    unique case (ph)
      sbpp_pkg::PH_ID: begin
        if (b == own_id || b == sbpp_pkg::BROADCAST_ID) begin
          held_id_next = b;
          phase_next   = sbpp_pkg::PH_LEN;
        end else begin
          phase_next = sbpp_pkg::PH_IDLE;
        end
      end
      sbpp_pkg::PH_LEN: begin
        if (b < sbpp_pkg::LEN_OVERHEAD) begin
          phase_next = sbpp_pkg::PH_IDLE;
        end else begin
          declared_params_next = b - sbpp_pkg::LEN_OVERHEAD;
          phase_next           = sbpp_pkg::PH_INST;
        end
      end
      sbpp_pkg::PH_INST: begin
        held_instruction_next = b;
        if (b == sbpp_pkg::SYNC_WRITE_INST || declared_params <= sbpp_pkg::MAX_PARAMS_B) begin
          phase_next       = (declared_params == 8'd0) ? sbpp_pkg::PH_CSUM
                                                       : sbpp_pkg::PH_PARAM;
          params_seen_next = 8'd0;
          param_sum_next   = 8'd0;
        end else begin
          phase_next = sbpp_pkg::PH_IDLE;
        end
      end
      sbpp_pkg::PH_PARAM: begin
        res_valid        = 1'b1;
        res.param_byte   = b;
        param_sum_next   = param_sum + b;
        params_seen_next = seen_inc;
        if (seen_inc == declared_params) begin
          phase_next = sbpp_pkg::PH_CSUM;
        end
      end
      sbpp_pkg::PH_CSUM: begin
        res_valid  = 1'b1;
        res.kind   = (~total == b) ? sbpp_pkg::KIND_GOOD : sbpp_pkg::KIND_BAD;
        phase_next = sbpp_pkg::PH_IDLE;
      end
      default: begin
        phase_next = sbpp_pkg::PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      own_id <= sbpp_pkg::OWN_ID_RESET;
    end else if (cfg_write) begin
      own_id <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      older_byte       <= 8'd0;
      prev_byte        <= 8'd0;
      phase            <= sbpp_pkg::PH_IDLE;
      held_id          <= 8'd0;
      held_instruction <= 8'd0;
      declared_params  <= 8'd0;
      params_seen      <= 8'd0;
      param_sum        <= 8'd0;
    end else if (step.fire) begin
      older_byte       <= older_byte_next;
      prev_byte        <= prev_byte_next;
      phase            <= phase_next;
      held_id          <= held_id_next;
      held_instruction <= held_instruction_next;
      declared_params  <= declared_params_next;
      params_seen      <= params_seen_next;
      param_sum        <= param_sum_next;
    end
  end

endmodule

### hdl/sbpp_output_stage.sv
module sbpp_output_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  logic               res_valid,
  input  sbpp_pkg::res_t     res,
  output logic               out_free,
  sbpp_result_if.source      result
);

  logic           out_valid;
  sbpp_pkg::res_t out_res;

  assign out_free = !out_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= advance && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && advance && res_valid) begin
      out_res <= res;
    end
  end

  assign result.valid       = out_valid;
  assign result.kind        = out_res.kind;
  assign result.packet_id   = out_res.packet_id;
  assign result.instruction = out_res.instruction;
  assign result.param_index = out_res.param_index;
  assign result.param_byte  = out_res.param_byte;
  assign result.param_total = out_res.param_total;
  assign result.broadcast   = out_res.broadcast;

endmodule

### hdl/servo_bus_packet_parser.sv
// Servo bus packet parser.
// rx carries one received serial word per handshake (valid/ready, accepted when
// both are high). The parser follows FF FF ID LEN INST PARAM... CSUM frames aimed
// at own_id or broadcast FE, and on result emits one word per parameter byte
// (kind 0, with its index) and one end word per packet (kind 1 good checksum,
// kind 2 mismatch), none if LEN < 2 or if INST is not 83 and params exceed 128.
// Bytes that cause no result are simply absorbed. cfg_write/cfg_data set
// own_id; write it only while idle. A word accepted on rx waits in the input
// register and its result, if any, goes to the result register. Throughput:
// one word per cycle unless result stalls, via the combinational parse step.
// Reset (rst, synchronous): own_id returns to 1, parser goes idle with the
// byte history, counters and checksum cleared, both registers emptied.
// Receiver stall: the result register holds its word; the input register
// still takes one more word, then rx.ready drops until result is taken.
// A two-FF sequence resyncs the parser in any phase.
module servo_bus_packet_parser (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_write,
  input  logic [7:0]     cfg_data,
  sbpp_byte_if.sink      rx,
  sbpp_result_if.source  result
);

  sbpp_pkg::step_t step;
  sbpp_pkg::res_t  res;
  logic            res_valid;
  logic            out_free;

  // hold each received word until the parse step can run
  sbpp_input_stage u_input (
    .clk      (clk),
    .rst      (rst),
    .rx       (rx),
    .out_free (out_free),
    .step     (step)
  );

  // advance the frame state by one word and form the result, if any
  sbpp_parse_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .step      (step),
    .res_valid (res_valid),
    .res       (res)
  );

  // register the result; drop words with no result
  sbpp_output_stage u_output (
    .clk       (clk),
    .rst       (rst),
    .advance   (step.fire),
    .res_valid (res_valid),
    .res       (res),
    .out_free  (out_free),
    .result    (result)
  );

endmodule
